[rtl/core/tor_pkg.sv]
// Package for the tracked object registry: payload types, codes and helpers.
`timescale 1ns / 1ps
package tor_pkg;

  localparam int DefSlots      = 1024;
  localparam int DefObjects    = 4096;
  localparam int DefValueBytes = 8;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;

  localparam logic [47:0] Mask48       = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] Max32        = 32'hFFFF_FFFF;
  localparam logic [10:0] CntTargetMax = 11'd2047;
  localparam logic [10:0] CntTargetRst = 11'd1024;
  localparam logic [31:0] OtherEst     = 32'd64;

  typedef enum logic [1:0] {
    OP_TRACK   = 2'd0,
    OP_UNTRACK = 2'd1,
    OP_MARK    = 2'd2,
    OP_COLLECT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    KIND_ARRAY    = 3'd0,
    KIND_OBJECT   = 3'd1,
    KIND_INSTANCE = 3'd2,
    KIND_STRING   = 3'd3,
    KIND_FUNCTION = 3'd4,
    KIND_OTHER    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CFG_GC_ENABLED      = 3'd0,
    CFG_COUNT_THRESHOLD = 3'd1,
    CFG_MEMORY_LIMIT    = 3'd2,
    CFG_BASE_ARRAY      = 3'd3,
    CFG_BASE_OBJECT     = 3'd4,
    CFG_BASE_INSTANCE   = 3'd5,
    CFG_BASE_STRING     = 3'd6,
    CFG_BASE_FUNCTION   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] object_id;
    logic [2:0]  object_kind;
    logic [15:0] element_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] moved_object;
    logic        moved_valid;
    logic        collect_requested;
    logic [10:0] live_count;
    logic [10:0] swept_count;
    logic [47:0] memory_usage;
    logic [10:0] peak_count;
    logic [31:0] allocations_since;
    logic [31:0] collections_total;
    logic [31:0] collected_total;
    logic [31:0] allocated_total;
  } out_item_t;

  // Control settings the sequencer needs
  typedef struct packed {
    logic        gc_enabled;
    logic [10:0] count_threshold;
    logic [47:0] mem_limit;
  } cfg_t;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? Max32 : s[31:0];
  endfunction

endpackage

[rtl/core/tor_cfg.sv]
// Configuration registers and per-item size estimate.
`timescale 1ns / 1ps
module tor_cfg import tor_pkg::*; #(
  parameter int ValueBytes = DefValueBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [2:0]          kind_i,
  input  logic [15:0]         count_i,
  output cfg_t                cfg_o,
  output logic [31:0]         est_o
);

  logic        en_q;
  logic [10:0] thr_q;
  logic [47:0] limit_q;
  logic [15:0] b_arr_q, b_obj_q, b_inst_q, b_str_q, b_fn_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b1;
      thr_q    <= 11'd1024;
      limit_q  <= '0;
      b_arr_q  <= 16'd64;
      b_obj_q  <= 16'd64;
      b_inst_q <= 16'd64;
      b_str_q  <= 16'd64;
      b_fn_q   <= 16'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GC_ENABLED:      en_q     <= cfg_wdata_i[0];
        CFG_COUNT_THRESHOLD: thr_q    <= cfg_wdata_i[10:0];
        CFG_MEMORY_LIMIT:    limit_q  <= cfg_wdata_i[47:0];
        CFG_BASE_ARRAY:      b_arr_q  <= cfg_wdata_i[15:0];
        CFG_BASE_OBJECT:     b_obj_q  <= cfg_wdata_i[15:0];
        CFG_BASE_INSTANCE:   b_inst_q <= cfg_wdata_i[15:0];
        CFG_BASE_STRING:     b_str_q  <= cfg_wdata_i[15:0];
        CFG_BASE_FUNCTION:   b_fn_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = '{gc_enabled: en_q, count_threshold: thr_q, mem_limit: limit_q};

  // estimate: base plus body for container kinds, saturated to 32 bits
  logic [32:0] body, est_w;
  assign body = 33'(count_i) * 33'(ValueBytes);

  always_comb begin
    unique case (kind_i)
      KIND_ARRAY:    est_w = 33'(b_arr_q) + body;
      KIND_OBJECT:   est_w = 33'(b_obj_q) + body;
      KIND_INSTANCE: est_w = 33'(b_inst_q) + body;
      KIND_STRING:   est_w = 33'(b_str_q);
      KIND_FUNCTION: est_w = 33'(b_fn_q);
      default:       est_w = 33'(OtherEst);
    endcase
  end

  assign est_o = est_w[32] ? Max32 : est_w[31:0];

endmodule

[rtl/core/tracked_object_registry_sweep_core.sv]
// Top level: object and slot memories, operation sequencer, statistics.
// Items are taken one at a time: a new item is accepted only once the last result is
// loaded into the output register. Untrack has an extra step when a slot moves. Collect
// partitions the slots, swapping where needed, then renumbers live objects and sweeps.
// Reset: the object memory is cleared one entry a cycle; no item is taken during
// that pass, config writes are. An output stall holds the sequencer in its result state.
`timescale 1ns / 1ps
module tracked_object_registry_sweep_core import tor_pkg::*; #(
  parameter int SLOTS       = DefSlots,
  parameter int OBJECTS     = DefObjects,
  parameter int VALUE_BYTES = DefValueBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int OW = $clog2(OBJECTS);
  localparam int SW = $clog2(SLOTS);
  localparam int CW = SW + 1;

  typedef struct packed {
    logic          tracked;
    logic          marked;
    logic [SW-1:0] slot;
    logic [31:0]   est;
  } obj_t;

  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001,
    S_IDLE  = 16'h0002,
    S_EXEC  = 16'h0004,
    S_UNT   = 16'h0008,
    S_UNT2  = 16'h0010,
    S_C_TOP = 16'h0020,
    S_C_S1  = 16'h0040,
    S_C_S2  = 16'h0080,
    S_G_TOP = 16'h0100,
    S_G_S1  = 16'h0200,
    S_G_S2  = 16'h0400,
    S_SWAP  = 16'h0800,
    S_R_TOP = 16'h1000,
    S_R_S1  = 16'h2000,
    S_R_S2  = 16'h4000,
    S_RESP  = 16'h8000
  } state_e;

  cfg_t        cfg;
  logic [31:0] in_est;

  tor_cfg #(.ValueBytes(VALUE_BYTES)) u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .kind_i(in_i.object_kind), .count_i(in_i.element_count),
    .cfg_o(cfg), .est_o(in_est)
  );

  // memories: one read and one write port each, registered read data
  obj_t          obj_mem [OBJECTS];
  logic [OW-1:0] slot_mem [SLOTS];

  logic          obj_we, slot_we;
  logic [OW-1:0] obj_raddr, obj_waddr, slot_wdata;
  logic [SW-1:0] slot_raddr, slot_waddr;
  obj_t          obj_wdata, obj_rdata_q;
  logic [OW-1:0] slot_rdata_q;

  always_ff @(posedge clk_i) begin
    if (obj_we) obj_mem[obj_waddr] <= obj_wdata;
    obj_rdata_q <= obj_mem[obj_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rdata_q <= slot_mem[slot_raddr];
  end

  // sequencer state
  state_e        state_q, state_d;
  logic [OW-1:0] clr_q, clr_d, id_q, id_d, moved_q, moved_d, cur_q, cur_d, gid_q, gid_d;
  logic [1:0]    op_q, op_d, status_q, status_d;
  logic          id_ok_q, id_ok_d, mvalid_q, mvalid_d, move_q, move_d, req_q, req_d;
  logic [31:0]   est_q, est_d;
  logic [CW-1:0] live_q, live_d, peak_q, peak_d, garbage_q, garbage_d;
  logic [CW-1:0] lp_q, lp_d, gb_q, gb_d, n_q, n_d, i_q, i_d;
  logic [SW-1:0] idx_q, idx_d;
  logic [47:0]   usage_q, usage_d, mt_q, mt_d;
  logic [10:0]   ct_q, ct_d;
  logic [31:0]   since_q, since_d, coll_q, coll_d, swept_q, swept_d, alloc_q, alloc_d;
  logic          out_valid_q, out_load;
  out_item_t     out_q;

  // shared arithmetic: charge, uncharge, targets
  logic [48:0]   u_sum;
  logic [47:0]   u_add, u_sub, u_dbl;
  logic [CW-1:0] live_p1, live_m1;
  logic [31:0]   want;
  obj_t          o;

  assign o       = obj_rdata_q;
  assign u_sum   = {1'b0, usage_q} + 49'(est_q);
  assign u_add   = u_sum[48] ? Mask48 : u_sum[47:0];
  assign u_sub   = (usage_q >= 48'(o.est)) ? usage_q - 48'(o.est) : '0;
  assign u_dbl   = usage_q[47] ? Mask48 : {usage_q[46:0], 1'b0};
  assign live_p1 = live_q + 1'b1;
  assign live_m1 = live_q - 1'b1;
  assign want    = 32'(lp_q) + ((32'(cfg.count_threshold) > 32'(lp_q)) ?
                   32'(cfg.count_threshold) : 32'(lp_q));

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    id_d      = id_q;
    op_d      = op_q;
    id_ok_d   = id_ok_q;
    est_d     = est_q;
    status_d  = status_q;
    moved_d   = moved_q;
    mvalid_d  = mvalid_q;
    move_d    = move_q;
    garbage_d = garbage_q;
    idx_d     = idx_q;
    cur_d     = cur_q;
    gid_d     = gid_q;
    lp_d      = lp_q;
    gb_d      = gb_q;
    n_d       = n_q;
    i_d       = i_q;
    live_d    = live_q;
    peak_d    = peak_q;
    usage_d   = usage_q;
    mt_d      = mt_q;
    ct_d      = ct_q;
    req_d     = req_q;
    since_d   = since_q;
    coll_d    = coll_q;
    swept_d   = swept_q;
    alloc_d   = alloc_q;
    out_load  = 1'b0;

    obj_we     = 1'b0;
    obj_waddr  = id_q;
    obj_wdata  = o;
    obj_raddr  = id_q;
    slot_we    = 1'b0;
    slot_waddr = lp_q[SW-1:0];
    slot_wdata = gid_q;
    slot_raddr = lp_q[SW-1:0];

    unique case (state_q)
      // clear tracked and marked bits after reset
      S_CLEAR: begin
        obj_we    = 1'b1;
        obj_waddr = clr_q;
        obj_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == OW'(OBJECTS - 1)) state_d = S_IDLE;
      end

      // take an item and start the read of its object entry
      S_IDLE: begin
        obj_raddr = OW'(in_i.object_id);
        if (in_valid_i) begin
          op_d      = in_i.operation;
          id_d      = OW'(in_i.object_id);
          id_ok_d   = (32'(in_i.object_id) < OBJECTS);
          est_d     = in_est;
          status_d  = ST_DONE;
          moved_d   = '0;
          mvalid_d  = 1'b0;
          garbage_d = '0;
          if (in_i.operation == OP_COLLECT) begin
            if (!cfg.gc_enabled) begin
              status_d = ST_IGNORED;
              state_d  = S_RESP;
            end else begin
              coll_d  = sat_add32(coll_q, 32'd1);
              lp_d    = '0;
              gb_d    = live_q;
              n_d     = live_q;
              state_d = S_C_TOP;
            end
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      // track, untrack, mark on the object entry just read
      S_EXEC: begin
        state_d = S_RESP;
        unique case (op_e'(op_q))
          OP_TRACK: begin
            if (!cfg.gc_enabled || !id_ok_q || o.tracked) begin
              status_d = ST_IGNORED;
            end else if (live_q == CW'(SLOTS)) begin
              status_d = ST_FULL;
            end else begin
              obj_we     = 1'b1;
              obj_wdata  = '{tracked: 1'b1, marked: o.marked,
                             slot: live_q[SW-1:0], est: est_q};
              slot_we    = 1'b1;
              slot_waddr = live_q[SW-1:0];
              slot_wdata = id_q;
              live_d     = live_p1;
              since_d    = sat_add32(since_q, 32'd1);
              alloc_d    = sat_add32(alloc_q, 32'd1);
              usage_d    = u_add;
              if (live_p1 > peak_q) peak_d = live_p1;
              if ((mt_q != '0 && u_add > mt_q) || (32'(live_p1) >= 32'(ct_q))) req_d = 1'b1;
            end
          end
          OP_UNTRACK: begin
            if (!id_ok_q || !o.tracked || live_q == '0) begin
              status_d = ST_IGNORED;
            end else begin
              obj_we     = 1'b1;
              obj_wdata  = '{tracked: 1'b0, marked: o.marked, slot: o.slot, est: o.est};
              slot_raddr = live_m1[SW-1:0];
              idx_d      = o.slot;
              move_d     = (CW'(o.slot) != live_m1);
              live_d     = live_m1;
              usage_d    = u_sub;
              state_d    = S_UNT;
            end
          end
          OP_MARK: begin
            if (!id_ok_q) begin
              status_d = ST_IGNORED;
            end else begin
              obj_we    = 1'b1;
              obj_wdata = '{tracked: o.tracked, marked: 1'b1, slot: o.slot, est: o.est};
            end
          end
          default: status_d = ST_IGNORED;
        endcase
      end

      // last slot fills the freed one
      S_UNT: begin
        if (move_q) begin
          slot_we    = 1'b1;
          slot_waddr = idx_q;
          slot_wdata = slot_rdata_q;
          obj_raddr  = slot_rdata_q;
          moved_d    = slot_rdata_q;
          mvalid_d   = 1'b1;
          state_d    = S_UNT2;
        end else begin
          state_d = S_RESP;
        end
      end

      S_UNT2: begin
        obj_we    = 1'b1;
        obj_waddr = moved_q;
        obj_wdata = '{tracked: o.tracked, marked: o.marked, slot: idx_q, est: o.est};
        state_d   = S_RESP;
      end

      // partition: scan up from the front for garbage
      S_C_TOP: begin
        if (lp_q < gb_q) begin
          slot_raddr = lp_q[SW-1:0];
          state_d    = S_C_S1;
        end else begin
          i_d     = '0;
          state_d = S_R_TOP;
        end
      end

      S_C_S1: begin
        obj_raddr = slot_rdata_q;
        cur_d     = slot_rdata_q;
        state_d   = S_C_S2;
      end

      S_C_S2: begin
        if (o.marked) begin
          lp_d    = lp_q + 1'b1;
          state_d = S_C_TOP;
        end else begin
          gb_d    = gb_q - 1'b1;
          state_d = S_G_TOP;
        end
      end

      // scan down from the back for a live object
      S_G_TOP: begin
        if (lp_q < gb_q) begin
          slot_raddr = gb_q[SW-1:0];
          state_d    = S_G_S1;
        end else begin
          i_d     = '0;
          state_d = S_R_TOP;
        end
      end

      S_G_S1: begin
        obj_raddr = slot_rdata_q;
        gid_d     = slot_rdata_q;
        state_d   = S_G_S2;
      end

      S_G_S2: begin
        if (o.marked) begin
          slot_we    = 1'b1;
          slot_waddr = lp_q[SW-1:0];
          slot_wdata = gid_q;
          state_d    = S_SWAP;
        end else begin
          gb_d    = gb_q - 1'b1;
          state_d = S_G_TOP;
        end
      end

      S_SWAP: begin
        slot_we    = 1'b1;
        slot_waddr = gb_q[SW-1:0];
        slot_wdata = cur_q;
        lp_d       = lp_q + 1'b1;
        state_d    = S_C_TOP;
      end

      // renumber live objects, sweep garbage, then close the collection
      S_R_TOP: begin
        if (i_q < n_q) begin
          slot_raddr = i_q[SW-1:0];
          state_d    = S_R_S1;
        end else begin
          garbage_d = n_q - lp_q;
          live_d    = lp_q;
          swept_d   = sat_add32(swept_q, 32'(n_q - lp_q));
          since_d   = '0;
          req_d     = 1'b0;
          ct_d      = (want > 32'(CntTargetMax)) ? CntTargetMax : want[10:0];
          if (cfg.mem_limit != '0) begin
            mt_d = (cfg.mem_limit > u_dbl) ? cfg.mem_limit : u_dbl;
          end
          state_d = S_RESP;
        end
      end

      S_R_S1: begin
        obj_raddr = slot_rdata_q;
        gid_d     = slot_rdata_q;
        state_d   = S_R_S2;
      end

      S_R_S2: begin
        obj_we    = 1'b1;
        obj_waddr = gid_q;
        if (i_q < lp_q) begin
          obj_wdata = '{tracked: o.tracked, marked: 1'b0, slot: i_q[SW-1:0], est: o.est};
        end else begin
          obj_wdata = '{tracked: 1'b0, marked: o.marked, slot: o.slot, est: o.est};
          usage_d   = u_sub;
        end
        i_d     = i_q + 1'b1;
        state_d = S_R_TOP;
      end

      // hand the result to the output register
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      id_q      <= '0;
      op_q      <= '0;
      id_ok_q   <= 1'b0;
      est_q     <= '0;
      status_q  <= '0;
      moved_q   <= '0;
      mvalid_q  <= 1'b0;
      move_q    <= 1'b0;
      garbage_q <= '0;
      idx_q     <= '0;
      cur_q     <= '0;
      gid_q     <= '0;
      lp_q      <= '0;
      gb_q      <= '0;
      n_q       <= '0;
      i_q       <= '0;
      live_q    <= '0;
      peak_q    <= '0;
      usage_q   <= '0;
      mt_q      <= '0;
      ct_q      <= CntTargetRst;
      req_q     <= 1'b0;
      since_q   <= '0;
      coll_q    <= '0;
      swept_q   <= '0;
      alloc_q   <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      id_q      <= id_d;
      op_q      <= op_d;
      id_ok_q   <= id_ok_d;
      est_q     <= est_d;
      status_q  <= status_d;
      moved_q   <= moved_d;
      mvalid_q  <= mvalid_d;
      move_q    <= move_d;
      garbage_q <= garbage_d;
      idx_q     <= idx_d;
      cur_q     <= cur_d;
      gid_q     <= gid_d;
      lp_q      <= lp_d;
      gb_q      <= gb_d;
      n_q       <= n_d;
      i_q       <= i_d;
      live_q    <= live_d;
      peak_q    <= peak_d;
      usage_q   <= usage_d;
      mt_q      <= mt_d;
      ct_q      <= ct_d;
      req_q     <= req_d;
      since_q   <= since_d;
      coll_q    <= coll_d;
      swept_q   <= swept_d;
      alloc_q   <= alloc_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= '{status: status_q, moved_object: 12'(moved_q), moved_valid: mvalid_q,
                 collect_requested: req_q, live_count: 11'(live_q),
                 swept_count: 11'(garbage_q), memory_usage: usage_q,
                 peak_count: 11'(peak_q), allocations_since: since_q,
                 collections_total: coll_q, collected_total: swept_q,
                 allocated_total: alloc_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // checks
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_q <= CW'(SLOTS)) && (peak_q >= live_q))
    else $error("live count out of range");

  a_part_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_C_TOP || state_q == S_G_TOP || state_q == S_R_TOP)
      |-> (lp_q <= gb_q) && (gb_q <= n_q) && (state_q != S_R_TOP || i_q <= n_q))
    else $error("partition pointers crossed");

  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o && !out_load)
    else $error("item taken during clearing pass");

  a_load_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q == S_IDLE) && out_valid_q)
    else $error("result not presented after load");

endmodule

[dv/tor_checker.sv]
// Checker for the object registry: predicts each item's result and compares it.
`timescale 1ns / 1ps
module tor_checker import tor_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  fail_cnt_o,
  output int                  pending_o
);

  // Configuration copy
  bit          gc_on;
  logic [10:0] grow_thr;
  logic [47:0] mem_floor;
  logic [15:0] kind_base [5];

  // Registry copy
  bit          is_tracked [DefObjects];
  bit          mark_bit   [DefObjects];
  logic [9:0]  slot_of    [DefObjects];
  logic [31:0] size_of    [DefObjects];
  logic [11:0] slot_ids   [DefSlots];
  int          live_cnt;
  logic [47:0] usage;
  int          cnt_target;
  logic [47:0] mem_target;
  bit          gc_request;
  int          peak;
  logic [31:0] allocs_since, gc_runs, swept_total, allocs_total;

  out_item_t   expected_results [$];

  function automatic logic [31:0] sat_bump(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] size_estimate(logic [2:0] kind, logic [15:0] cnt);
    logic [33:0] e;
    e = 34'(cnt) * 34'(DefValueBytes);
    case (kind)
      KIND_ARRAY, KIND_OBJECT, KIND_INSTANCE: e = e + 34'(kind_base[kind]);
      KIND_STRING, KIND_FUNCTION: e = 34'(kind_base[kind]);
      default: e = 34'd64;
    endcase
    return (e > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
  endfunction

  function automatic void release_size(logic [31:0] e);
    usage = (usage >= 48'(e)) ? usage - 48'(e) : 48'd0;
  endfunction

  function automatic void clear_registry();
    foreach (is_tracked[i]) begin
      is_tracked[i] = 0;
      mark_bit[i]   = 0;
    end
    live_cnt = 0; usage = 0; cnt_target = 1024; mem_target = 0; gc_request = 0;
    peak = 0; allocs_since = 0; gc_runs = 0; swept_total = 0; allocs_total = 0;
    gc_on = 1; grow_thr = 11'd1024; mem_floor = 0;
    foreach (kind_base[k]) kind_base[k] = 16'd64;
  endfunction

  // Apply one item to the registry copy and return its result
  function automatic out_item_t registry_step(in_item_t it);
    out_item_t   r;
    logic [11:0] id, last;
    logic [31:0] e;
    logic [48:0] sum;
    logic [11:0] t;
    int          idx, lo, hi, n, want;
    r = '0;
    id = it.object_id;
    r.status = ST_DONE;
    case (op_e'(it.operation))
      OP_TRACK: begin
        if (!gc_on || is_tracked[id]) r.status = ST_IGNORED;
        else if (live_cnt >= DefSlots) r.status = ST_FULL;
        else begin
          e = size_estimate(it.object_kind, it.element_count);
          size_of[id] = e;
          slot_of[id] = 10'(live_cnt);
          slot_ids[live_cnt] = id;
          live_cnt++;
          is_tracked[id] = 1;
          allocs_since = sat_bump(allocs_since, 1);
          allocs_total = sat_bump(allocs_total, 1);
          sum = {1'b0, usage} + 49'(e);
          usage = sum[48] ? Mask48 : sum[47:0];
          if (live_cnt > peak) peak = live_cnt;
          if (mem_target > 0 && usage > mem_target) gc_request = 1;
          if (live_cnt >= cnt_target) gc_request = 1;
        end
      end
      OP_UNTRACK: begin
        if (!is_tracked[id] || live_cnt == 0) r.status = ST_IGNORED;
        else begin
          idx = slot_of[id];
          last = slot_ids[live_cnt - 1];
          if (idx + 1 != live_cnt) begin
            slot_ids[idx] = last;
            slot_of[last] = 10'(idx);
            r.moved_object = last;
            r.moved_valid = 1'b1;
          end
          live_cnt--;
          is_tracked[id] = 0;
          release_size(size_of[id]);
        end
      end
      OP_MARK: mark_bit[id] = 1;
      default: begin
        if (!gc_on) r.status = ST_IGNORED;
        else begin
          gc_runs = sat_bump(gc_runs, 1);
          lo = 0; hi = live_cnt; n = live_cnt;
          // two-pointer partition: marked to the front, garbage to the back
          while (lo < hi) begin
            if (mark_bit[slot_ids[lo]]) begin
              lo++;
              continue;
            end
            do hi--; while (lo < hi && !mark_bit[slot_ids[hi]]);
            if (lo == hi) break;
            t = slot_ids[lo];
            slot_ids[lo] = slot_ids[hi];
            slot_ids[hi] = t;
            lo++;
          end
          for (int i = 0; i < lo; i++) begin
            slot_of[slot_ids[i]] = 10'(i);
            mark_bit[slot_ids[i]] = 0;
          end
          for (int i = lo; i < n; i++) begin
            is_tracked[slot_ids[i]] = 0;
            release_size(size_of[slot_ids[i]]);
          end
          live_cnt = lo;
          r.swept_count = 11'(n - lo);
          swept_total = sat_bump(swept_total, 32'(n - lo));
          allocs_since = 0;
          gc_request = 0;
          want = lo + ((int'(grow_thr) > lo) ? int'(grow_thr) : lo);
          cnt_target = (want > 2047) ? 2047 : want;
          if (mem_floor > 0) begin
            sum = {usage, 1'b0};
            if (sum > 49'(Mask48)) sum = 49'(Mask48);
            mem_target = (mem_floor > sum[47:0]) ? mem_floor : sum[47:0];
          end
        end
      end
    endcase
    r.collect_requested = gc_request;
    r.live_count = 11'(live_cnt);
    r.memory_usage = usage;
    r.peak_count = 11'(peak);
    r.allocations_since = allocs_since;
    r.collections_total = gc_runs;
    r.collected_total = swept_total;
    r.allocated_total = allocs_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_cnt_o++;
    end
  endfunction

  // Watch both channels and the config port
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      clear_registry();
      expected_results.delete();
      fail_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_GC_ENABLED:      gc_on = cfg_wdata_i[0];
          CFG_COUNT_THRESHOLD: grow_thr = cfg_wdata_i[10:0];
          CFG_MEMORY_LIMIT:    mem_floor = cfg_wdata_i;
          default:             kind_base[cfg_idx_i - CFG_BASE_ARRAY] = cfg_wdata_i[15:0];
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %p", $time, out_i);
          fail_cnt_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_i.status);
          check_field("moved_object", want.moved_object, out_i.moved_object);
          check_field("moved_valid", want.moved_valid, out_i.moved_valid);
          check_field("collect_requested", want.collect_requested, out_i.collect_requested);
          check_field("live_count", want.live_count, out_i.live_count);
          check_field("swept_count", want.swept_count, out_i.swept_count);
          check_field("memory_usage", want.memory_usage, out_i.memory_usage);
          check_field("peak_count", want.peak_count, out_i.peak_count);
          check_field("allocations_since", want.allocations_since, out_i.allocations_since);
          check_field("collections_total", want.collections_total, out_i.collections_total);
          check_field("collected_total", want.collected_total, out_i.collected_total);
          check_field("allocated_total", want.allocated_total, out_i.allocated_total);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.insert(expected_results.size(), registry_step(in_i));
      end
    end
  end

  assign pending_o = expected_results.size();

endmodule

[dv/testbench.sv]
// Testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
  import tor_pkg::*;

  localparam int StallLimit = 40000;
  localparam int LongHold   = 300;

  logic                clk_i, rst_ni;
  logic                in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_item_t            in_i;
  out_item_t           out_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  int                  fail_cnt, pending;
  int                  send_idle_pct, recv_stall_pct, hold_cnt, quiet_cycles;
  bit                  hold_arm;

  tracked_object_registry_sweep_core i_dut (.*);

  tor_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_i(out_o),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off once armed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 0;
      hold_cnt = 0;
    end else if (hold_arm && hold_cnt < LongHold) begin
      out_stall_i <= 1;
      hold_cnt++;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, logic [11:0] id, logic [2:0] kind, logic [15:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_i <= '{operation: op, object_id: id, object_kind: kind, element_count: cnt};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [47:0] data);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic random_bases();
    for (int k = CFG_BASE_ARRAY; k <= CFG_BASE_FUNCTION; k++)
      cfg_write(cfg_idx_e'(k), 48'($urandom_range(65535)));
  endtask

  // Random traffic over a small id pool so untrack and mark hit tracked objects
  task automatic random_burst(int n, int pool);
    logic [11:0] id;
    int          pick;
    logic [1:0]  op;
    for (int i = 0; i < n; i++) begin
      id = ($urandom_range(99) < 90) ? 12'($urandom_range(pool)) : 12'($urandom);
      pick = $urandom_range(99);
      op = (pick < 42) ? OP_TRACK : (pick < 64) ? OP_UNTRACK : (pick < 94) ? OP_MARK
                                                             : OP_COLLECT;
      send(op, id, 3'($urandom_range(7)), 16'($urandom));
    end
  endtask

  initial begin
    in_valid_i = 0; in_i = '0; cfg_we_i = 0; cfg_idx_i = '0; cfg_wdata_i = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_arm = 0;
    rst_ni = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: field extremes, every operation and kind, ignored and moved cases
    cfg_write(CFG_BASE_ARRAY, 48'd0);
    cfg_write(CFG_BASE_OBJECT, 48'hFFFF);
    cfg_write(CFG_BASE_INSTANCE, 48'd1234);
    cfg_write(CFG_BASE_STRING, 48'hFFFF);
    cfg_write(CFG_BASE_FUNCTION, 48'd0);
    cfg_write(CFG_COUNT_THRESHOLD, 48'd1);
    cfg_write(CFG_MEMORY_LIMIT, 48'd100);
    send(OP_TRACK, 12'd0, KIND_ARRAY, 16'hFFFF);
    send(OP_TRACK, 12'hFFF, KIND_OBJECT, 16'hFFFF);
    send(OP_TRACK, 12'd5, KIND_INSTANCE, 16'd0);
    send(OP_TRACK, 12'd6, KIND_STRING, 16'd7);
    send(OP_TRACK, 12'd7, KIND_FUNCTION, 16'd7);
    send(OP_TRACK, 12'd8, KIND_OTHER, 16'hFFFF);
    send(OP_TRACK, 12'd9, 3'($urandom_range(7, 6)), 16'h1234);
    send(OP_TRACK, 12'd0, KIND_ARRAY, 16'd1);
    send(OP_UNTRACK, 12'd100, KIND_ARRAY, 16'd0);
    send(OP_MARK, 12'd100, KIND_ARRAY, 16'd0);
    send(OP_UNTRACK, 12'd5, KIND_ARRAY, 16'd0);
    send(OP_UNTRACK, 12'd8, KIND_ARRAY, 16'd0);
    send(OP_MARK, 12'd0, KIND_ARRAY, 16'd0);
    send(OP_MARK, 12'd7, KIND_ARRAY, 16'd0);
    send(OP_COLLECT, 12'd0, KIND_ARRAY, 16'd0);
    send(OP_COLLECT, 12'd0, KIND_ARRAY, 16'd0);
    send(OP_TRACK, 12'd100, KIND_ARRAY, 16'd3);
    drain();

    // Disabled: track and collect ignored, untrack and mark still work
    cfg_write(CFG_GC_ENABLED, 48'd0);
    send(OP_TRACK, 12'd200, KIND_ARRAY, 16'd1);
    send(OP_UNTRACK, 12'd0, KIND_ARRAY, 16'd0);
    send(OP_MARK, 12'd7, KIND_ARRAY, 16'd0);
    send(OP_COLLECT, 12'd0, KIND_ARRAY, 16'd0);
    drain();
    cfg_write(CFG_GC_ENABLED, 48'd1);
    cfg_write(CFG_MEMORY_LIMIT, 48'd0);
    cfg_write(CFG_COUNT_THRESHOLD, 48'd1024);

    // Random phases with different idling and settings
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 19 : 65) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 19 : 65) : 0;
      random_bases();
      case (ph)
        0: begin
          cfg_write(CFG_COUNT_THRESHOLD, 48'd1);
          cfg_write(CFG_MEMORY_LIMIT, 48'd5000);
        end
        1: begin
          cfg_write(CFG_COUNT_THRESHOLD, 48'd1024);
          cfg_write(CFG_MEMORY_LIMIT, Mask48);
        end
        2: begin
          cfg_write(CFG_COUNT_THRESHOLD, 48'($urandom_range(1024, 1)));
          cfg_write(CFG_MEMORY_LIMIT, 48'($urandom_range(2000000)));
        end
        default: begin
          cfg_write(CFG_COUNT_THRESHOLD, 48'd20);
          cfg_write(CFG_MEMORY_LIMIT, 48'd0);
        end
      endcase
      if (ph == 0) hold_arm = 1;
      random_burst(100, 47);
      random_burst(100, (ph == 1) ? 4095 : 15);
      drain();
    end

    // Short pass: mark some, track a run of objects, untrack one, then sweep
    send_idle_pct = 0;
    recv_stall_pct = 10;
    cfg_write(CFG_COUNT_THRESHOLD, 48'd1024);
    send(OP_COLLECT, 12'd0, KIND_ARRAY, 16'd0);
    for (int i = 0; i < 16; i++) begin
      if (i % 3 == 0) send(OP_MARK, 12'(i + 1000), KIND_ARRAY, 16'd0);
      send(OP_TRACK, 12'(i + 1000), 3'($urandom_range(7)), 16'($urandom));
    end
    send(OP_UNTRACK, 12'd1005, KIND_ARRAY, 16'd0);
    send(OP_TRACK, 12'd3000, KIND_ARRAY, 16'd0);
    send(OP_COLLECT, 12'd0, KIND_ARRAY, 16'd0);
    send(OP_COLLECT, 12'd0, KIND_ARRAY, 16'd0);
    drain();
    repeat (20) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
